// ===== sv/twcp_pkg.sv =====
// Package for the textured wall column pixel shader.
// Holds the command codes, configuration register indexes and color source codes.
// No dependencies.
package twcp_pkg;

    localparam int COLOR_W = 24;
    localparam int INDEX_W = 20;
    localparam int CFG_IDX_W = 2;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RENDER = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_CEILING_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_STRIDE = 2'd2;

    localparam logic [10:0] STRIDE_RESET = 11'd1024;

    typedef enum logic [1:0] {
        SRC_TEXEL = 2'd0,
        SRC_CEILING = 2'd1,
        SRC_FLOOR = 2'd2
    } color_src_t;

endpackage

// ===== sv/textured_wall_column_pixel.sv =====
// Top level of the textured wall column pixel shader: texel loads and pixel renders.
// Depends on twcp_pkg. Holds the texture memory and the pipelined texel row divider.
//
//  channel   direction  handshake          payload
//  s_*       in         s_valid/s_ready    command, side, pixel, span, hit, texel
//  m_*       out        m_valid/m_ready    pixel_index, pixel_color
//  cfg_*     in         cfg_we             cfg_index, cfg_wdata
//
// One transaction per cycle while the pipeline is not held. Each passes the entry register, the
// restoring divider (one quotient bit per stage plus a clamp stage) and the texture memory.
// Reset (synchronous, aresetn low) empties the pipeline and restores the registers;
// the texture memory is not cleared and must be loaded before it is read.
// The whole pipeline holds only when a result waits at the output and another reaches it.
// TILE must be a power of two.
module textured_wall_column_pixel #(
    parameter int TILE = 64,
    parameter int SCREEN_ROWS = 1024,
    parameter int SCREEN_COLS = 1024,
    parameter int TEXTURES = 4
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [twcp_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [twcp_pkg::COLOR_W-1:0]          cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic                                  s_command,
    input  logic [1:0]                            s_texture_side,
    input  logic [9:0]                            s_col_x,
    input  logic [9:0]                            s_row_y,
    input  logic [twcp_pkg::COLOR_W-1:0]          s_texel_color,
    input  logic [10:0]                           s_top_row,
    input  logic [10:0]                           s_bottom_row,
    input  logic signed [15:0]                    s_dist_from_top,
    input  logic [15:0]                           s_wall_height,
    input  logic [15:0]                           s_hit_x,
    input  logic [15:0]                           s_hit_y,
    input  logic                                  s_vertical_hit,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [twcp_pkg::INDEX_W-1:0]          m_pixel_index,
    output logic [twcp_pkg::COLOR_W-1:0]          m_pixel_color
);

    localparam int QW = $clog2(TILE);
    localparam int NW = 16 + QW;
    localparam int NS = QW + 2;
    localparam int DEPTH = TEXTURES * TILE * TILE;
    localparam int AW = $clog2(DEPTH);

    typedef struct packed {
        logic                          is_load;
        twcp_pkg::color_src_t          src;
        logic [1:0]                    side;
        logic [QW-1:0]                 tcol;
        logic [QW-1:0]                 lrow;
        logic [twcp_pkg::COLOR_W-1:0]  texel;
        logic [twcp_pkg::INDEX_W-1:0]  index;
        logic [NW-1:0]                 rem;
        logic [15:0]                   hgt;
        logic [QW:0]                   quo;
    } stage_t;

    // configuration registers
    logic [twcp_pkg::COLOR_W-1:0] ceiling_reg;
    logic [twcp_pkg::COLOR_W-1:0] floor_reg;
    logic [10:0]                  stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ceiling_reg <= '0;
            floor_reg <= '0;
            stride_reg <= twcp_pkg::STRIDE_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                twcp_pkg::CFG_CEILING_COLOR: ceiling_reg <= cfg_wdata;
                twcp_pkg::CFG_FLOOR_COLOR:   floor_reg <= cfg_wdata;
                twcp_pkg::CFG_FRAME_STRIDE:  stride_reg <= cfg_wdata[10:0];
                default: ;
            endcase
        end
    end

    // pipeline control
    logic            pipe_en;
    logic [NS-1:0]   st_valid_reg;
    stage_t          st_reg [NS];
    stage_t          st_next [NS];
    logic            entry_ok;
    logic            mem_valid_reg;
    twcp_pkg::color_src_t          mem_src_reg;
    logic [twcp_pkg::INDEX_W-1:0]  mem_index_reg;
    logic [twcp_pkg::COLOR_W-1:0]  mem_rdata_reg;
    logic                          m_valid_reg;
    logic [twcp_pkg::INDEX_W-1:0]  m_index_reg;
    logic [twcp_pkg::COLOR_W-1:0]  m_color_reg;

    // hold everything only when a result is waiting and another one is about to land
    assign pipe_en = !(m_valid_reg && !m_ready && mem_valid_reg);
    assign s_ready = pipe_en;

    // entry decode
    logic                 side_ok;
    logic                 load_ok;
    logic                 on_screen;
    logic signed [16:0]   row_sum;
    logic [20:0]          row_prod;

    always_comb begin
        side_ok = {1'b0, s_texture_side} < 3'(TEXTURES);
        load_ok = side_ok && (s_col_x < 10'(TILE)) && (s_row_y < 10'(TILE));
        on_screen = ({1'b0, s_row_y} < 11'(SCREEN_ROWS)) &&
                    ({1'b0, s_col_x} < 11'(SCREEN_COLS));
        entry_ok = (s_command == twcp_pkg::CMD_LOAD) ? load_ok : on_screen;
        row_sum = $signed({7'd0, s_row_y}) + 17'(s_dist_from_top);
        row_prod = 21'(s_row_y) * 21'(stride_reg);

        st_next[0].is_load = (s_command == twcp_pkg::CMD_LOAD);
        if ({1'b0, s_row_y} >= s_bottom_row) begin
            st_next[0].src = twcp_pkg::SRC_FLOOR;
        end else if ({1'b0, s_row_y} < s_top_row) begin
            st_next[0].src = twcp_pkg::SRC_CEILING;
        end else begin
            st_next[0].src = twcp_pkg::SRC_TEXEL;
        end
        if (st_next[0].is_load || side_ok) begin
            st_next[0].side = s_texture_side;
        end else begin
            st_next[0].side = 2'(TEXTURES - 1);
        end
        if (st_next[0].is_load) begin
            st_next[0].tcol = s_col_x[QW-1:0];
        end else begin
            st_next[0].tcol = s_vertical_hit ? s_hit_y[QW-1:0] : s_hit_x[QW-1:0];
        end
        st_next[0].lrow = s_row_y[QW-1:0];
        st_next[0].texel = s_texel_color;
        st_next[0].index = 20'(row_prod + 21'(s_col_x));
        // a negative row sum (row plus offset) always lands on texel row zero
        st_next[0].rem = row_sum[16] ? '0 : {row_sum[15:0], {QW{1'b0}}};
        st_next[0].hgt = (s_wall_height == 16'd0) ? 16'd1 : s_wall_height;
        st_next[0].quo = '0;
    end

    // restoring divider: stage k tests quotient bit QW-(k-1); the top bit means clamp
    for (genvar k = 1; k < NS; k++) begin : g_div
        logic [NW-1:0] dvs;
        always_comb begin
            dvs = NW'(st_reg[k-1].hgt) << (QW - (k - 1));
            st_next[k] = st_reg[k-1];
            if (st_reg[k-1].rem >= dvs) begin
                st_next[k].rem = st_reg[k-1].rem - dvs;
                st_next[k].quo[QW-(k-1)] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= '0;
        end else if (pipe_en) begin
            st_valid_reg <= {st_valid_reg[NS-2:0], s_valid && entry_ok};
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            for (int k = 0; k < NS; k++) begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    // texture memory: loads and renders reach it in order, so no forwarding is needed
    logic [twcp_pkg::COLOR_W-1:0] tex_mem [DEPTH];
    stage_t         last;
    logic [QW-1:0]  tex_row;
    logic [AW-1:0]  tex_addr;
    logic           mem_we;

    always_comb begin
        last = st_reg[NS-1];
        tex_row = last.quo[QW] ? QW'(TILE - 1) : last.quo[QW-1:0];
        if (last.is_load) begin
            tex_addr = AW'({last.side, last.lrow, last.tcol});
        end else begin
            tex_addr = AW'({last.side, tex_row, last.tcol});
        end
        mem_we = pipe_en && st_valid_reg[NS-1] && last.is_load;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tex_mem[tex_addr] <= last.texel;
        end
        if (pipe_en) begin
            mem_rdata_reg <= tex_mem[tex_addr];
            mem_src_reg <= last.src;
            mem_index_reg <= last.index;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            // drop loads here: they give no result
            mem_valid_reg <= st_valid_reg[NS-1] && !last.is_load;
        end
    end

    // output register
    logic [twcp_pkg::COLOR_W-1:0] color_sel;

    always_comb begin
        case (mem_src_reg)
            twcp_pkg::SRC_CEILING: color_sel = ceiling_reg;
            twcp_pkg::SRC_FLOOR:   color_sel = floor_reg;
            default:               color_sel = mem_rdata_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en && mem_valid_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en && mem_valid_reg) begin
            m_index_reg <= mem_index_reg;
            m_color_reg <= color_sel;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_pixel_index = m_index_reg;
    assign m_pixel_color = m_color_reg;

    // a result waiting behind a stalled output must block new transactions
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready && mem_valid_reg) |-> !s_ready)
        else $error("input accepted while output stage is blocked");

    // a stall freezes the pipeline occupancy
    assert property (@(posedge aclk) disable iff (!aresetn)
        !pipe_en |=> $stable(st_valid_reg) && $stable(mem_valid_reg))
        else $error("pipeline moved during a stall");

    // without overflow the divider must end with a remainder below the divisor
    assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg[NS-1] && !last.is_load && !last.quo[QW]) |->
            (last.rem < NW'(last.hgt)))
        else $error("divider remainder not below wall height");

    // the texture memory is written only by a load leaving the divider
    assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (st_valid_reg[NS-1] && pipe_en))
        else $error("texture write without a valid load");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for textured_wall_column_pixel: texel loads, pixel renders,
// register settings, random idling on both channels and a long output hold-off.
// Depends on twcp_pkg and the textured_wall_column_pixel RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TILE = 64;
    localparam int TEXTURES = 4;
    localparam int TEXEL_COUNT = TEXTURES * TILE * TILE;
    localparam int PIPE_LATENCY = 10;
    localparam int SETTLE_CYCLES = 3 * PIPE_LATENCY;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS = 160;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic                         command;
        logic [1:0]                   side;
        logic [9:0]                   col;
        logic [9:0]                   row;
        logic [twcp_pkg::COLOR_W-1:0] texel;
        logic [10:0]                  top;
        logic [10:0]                  bottom;
        logic signed [15:0]           row_offset;
        logic [15:0]                  height;
        logic [15:0]                  hit_x;
        logic [15:0]                  hit_y;
        logic                         vertical;
    } shader_txn_t;

    typedef struct {
        logic [twcp_pkg::INDEX_W-1:0] index;
        logic [twcp_pkg::COLOR_W-1:0] color;
    } pixel_t;

    class frame_pixel_scoreboard;
        logic [twcp_pkg::COLOR_W-1:0] texels [TEXEL_COUNT];
        bit                           loaded [TEXEL_COUNT];
        logic [twcp_pkg::COLOR_W-1:0] ceil_rgb;
        logic [twcp_pkg::COLOR_W-1:0] ground_rgb;
        logic [10:0]                  frame_stride;
        pixel_t                       pending_pixels [$];
        int                           errors;

        function new();
            ceil_rgb = '0;
            ground_rgb = '0;
            frame_stride = twcp_pkg::STRIDE_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [twcp_pkg::CFG_IDX_W-1:0] idx,
                                logic [twcp_pkg::COLOR_W-1:0] data);
            case (idx)
                twcp_pkg::CFG_CEILING_COLOR: ceil_rgb = data;
                twcp_pkg::CFG_FLOOR_COLOR: ground_rgb = data;
                twcp_pkg::CFG_FRAME_STRIDE: frame_stride = data[10:0];
                default: ;
            endcase
        endfunction

        // Texel a render reads, or -1 when its row falls outside the wall span.
        function int span_texel(shader_txn_t t);
            longint      r;
            longint      d;
            longint      h;
            longint      q;
            int          ts;
            logic [15:0] hit;
            if (t.row >= t.bottom || t.row < t.top)
                return -1;
            r = longint'(t.row);
            d = longint'(t.row_offset);
            h = (t.height == 16'd0) ? 64'sd1 : longint'(t.height);
            q = (r + d) * TILE / h;
            if (q < 0)
                q = 0;
            if (q > TILE - 1)
                q = TILE - 1;
            hit = t.vertical ? t.hit_y : t.hit_x;
            ts = (t.side < TEXTURES) ? int'(t.side) : TEXTURES - 1;
            return (ts * TILE + int'(q)) * TILE + int'(hit % TILE);
        endfunction

        function void accept_txn(shader_txn_t t);
            int     addr;
            pixel_t px;
            if (t.command == twcp_pkg::CMD_LOAD) begin
                if (t.col < TILE && t.row < TILE && t.side < TEXTURES) begin
                    addr = (int'(t.side) * TILE + int'(t.row)) * TILE + int'(t.col);
                    texels[addr] = t.texel;
                    loaded[addr] = 1'b1;
                end
                return;
            end
            addr = span_texel(t);
            if (t.row >= t.bottom)
                px.color = ground_rgb;
            else if (t.row < t.top)
                px.color = ceil_rgb;
            else
                px.color = texels[addr];
            px.index = 20'(20'(t.row) * 20'(frame_stride) + 20'(t.col));
            pending_pixels.push_back(px);
        endfunction

        function void fail(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("mismatch: %s", msg);
        endfunction

        function void check_pixel(logic [twcp_pkg::INDEX_W-1:0] index,
                                  logic [twcp_pkg::COLOR_W-1:0] color);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                fail($sformatf("unexpected pixel index %0d color %06h", index, color));
                return;
            end
            want = pending_pixels.pop_front();
            if (index !== want.index)
                fail($sformatf("pixel_index expected %0d got %0d", want.index, index));
            if (color !== want.color)
                fail($sformatf("pixel_color expected %06h got %06h (index %0d)",
                               want.color, color, want.index));
        endfunction

        function int close_out();
            if (pending_pixels.size() != 0) begin
                fail($sformatf("%0d pixels never came out", pending_pixels.size()));
                errors += pending_pixels.size() - 1;
            end
            return errors;
        endfunction
    endclass

    logic                           aclk = 1'b0;
    logic                           aresetn;
    logic                           cfg_we;
    logic [twcp_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [twcp_pkg::COLOR_W-1:0]   cfg_wdata;
    logic                           s_valid;
    logic                           s_ready;
    logic                           s_command;
    logic [1:0]                     s_texture_side;
    logic [9:0]                     s_col_x;
    logic [9:0]                     s_row_y;
    logic [twcp_pkg::COLOR_W-1:0]   s_texel_color;
    logic [10:0]                    s_top_row;
    logic [10:0]                    s_bottom_row;
    logic signed [15:0]             s_dist_from_top;
    logic [15:0]                    s_wall_height;
    logic [15:0]                    s_hit_x;
    logic [15:0]                    s_hit_y;
    logic                           s_vertical_hit;
    logic                           m_valid;
    logic                           m_ready;
    logic [twcp_pkg::INDEX_W-1:0]   m_pixel_index;
    logic [twcp_pkg::COLOR_W-1:0]   m_pixel_color;

    bit src_gaps = 1'b1;
    bit sink_stalls = 1'b1;
    bit hold_off_req = 1'b0;

    frame_pixel_scoreboard sb = new();

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    textured_wall_column_pixel u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_texture_side  (s_texture_side),
        .s_col_x         (s_col_x),
        .s_row_y         (s_row_y),
        .s_texel_color   (s_texel_color),
        .s_top_row       (s_top_row),
        .s_bottom_row    (s_bottom_row),
        .s_dist_from_top (s_dist_from_top),
        .s_wall_height   (s_wall_height),
        .s_hit_x         (s_hit_x),
        .s_hit_y         (s_hit_y),
        .s_vertical_hit  (s_vertical_hit),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_index   (m_pixel_index),
        .m_pixel_color   (m_pixel_color)
    );

    function automatic shader_txn_t random_txn();
        shader_txn_t t;
        t.command = 1'($urandom);
        t.side = 2'($urandom);
        t.col = 10'($urandom);
        t.row = 10'($urandom);
        t.texel = 24'($urandom);
        t.top = 11'($urandom_range(0, 1024));
        t.bottom = 11'($urandom_range(0, 1024));
        t.row_offset = 16'($urandom);
        t.height = 16'($urandom);
        t.hit_x = 16'($urandom);
        t.hit_y = 16'($urandom);
        t.vertical = 1'($urandom);
        return t;
    endfunction

    task automatic drive_txn(shader_txn_t t);
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_command <= t.command;
        s_texture_side <= t.side;
        s_col_x <= t.col;
        s_row_y <= t.row;
        s_texel_color <= t.texel;
        s_top_row <= t.top;
        s_bottom_row <= t.bottom;
        s_dist_from_top <= t.row_offset;
        s_wall_height <= t.height;
        s_hit_x <= t.hit_x;
        s_hit_y <= t.hit_y;
        s_vertical_hit <= t.vertical;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.accept_txn(t);
    endtask

    task automatic send_load(logic [1:0] side, logic [9:0] col, logic [9:0] row,
                             logic [twcp_pkg::COLOR_W-1:0] color);
        shader_txn_t t;
        t = random_txn();
        t.command = twcp_pkg::CMD_LOAD;
        t.side = side;
        t.col = col;
        t.row = row;
        t.texel = color;
        drive_txn(t);
    endtask

    // Load the texel a render will read first if nothing was ever written there.
    task automatic send_render(shader_txn_t t);
        int addr;
        t.command = twcp_pkg::CMD_RENDER;
        addr = sb.span_texel(t);
        if (addr >= 0 && !sb.loaded[addr])
            send_load(2'(addr / (TILE * TILE)), 10'(addr % TILE), 10'((addr / TILE) % TILE),
                      24'($urandom));
        drive_txn(t);
    endtask

    task automatic render_at(logic [1:0] side, logic [9:0] col, logic [9:0] row,
                             logic [10:0] top, logic [10:0] bottom,
                             logic signed [15:0] offset,
                             logic [15:0] height, logic [15:0] hit, logic vert);
        shader_txn_t t;
        t = random_txn();
        t.side = side;
        t.col = col;
        t.row = row;
        t.top = top;
        t.bottom = bottom;
        t.row_offset = offset;
        t.height = height;
        t.vertical = vert;
        if (vert)
            t.hit_y = hit;
        else
            t.hit_x = hit;
        send_render(t);
    endtask

    task automatic random_item();
        shader_txn_t t;
        int          pick;
        t = random_txn();
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            t.command = twcp_pkg::CMD_LOAD;
            if ($urandom_range(0, 5) != 0) begin
                t.col = 10'($urandom_range(0, TILE - 1));
                t.row = 10'($urandom_range(0, TILE - 1));
            end
            drive_txn(t);
        end else begin
            // Plausible wall column: row inside the span, offset and height matching it.
            if (pick < 70) begin
                t.top = 11'($urandom_range(0, 1024));
                t.bottom = 11'($urandom_range(t.top, 1024));
                if (t.bottom > t.top)
                    t.row = 10'($urandom_range(t.top, t.bottom - 1));
                t.row_offset = 16'($urandom_range(0, 4) - 2 - int'(t.top));
                t.height = 16'(t.bottom - t.top);
                if ($urandom_range(0, 3) == 0)
                    t.height = 16'(t.height + $urandom_range(0, 64));
            end
            send_render(t);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [twcp_pkg::CFG_IDX_W-1:0] idx,
                             logic [twcp_pkg::COLOR_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.write_reg(idx, data);
    endtask

    task automatic configure(logic [twcp_pkg::COLOR_W-1:0] ceiling,
                             logic [twcp_pkg::COLOR_W-1:0] floor_rgb,
                             logic [twcp_pkg::COLOR_W-1:0] stride_word);
        write_reg(twcp_pkg::CFG_CEILING_COLOR, ceiling);
        write_reg(twcp_pkg::CFG_FLOOR_COLOR, floor_rgb);
        write_reg(twcp_pkg::CFG_FRAME_STRIDE, stride_word);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase();
        repeat (PHASE_ITEMS) random_item();
        settle();
    endtask

    // Output side: random stalls, and one long hold-off on request.
    initial begin
        forever begin
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                hold_off_req = 1'b0;
            end else if (sink_stalls && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_pixel(m_pixel_index, m_pixel_color);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                quiet = 0;
            else
                quiet++;
        end
        $display("testbench: errors");
        $finish;
    end

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= twcp_pkg::CFG_CEILING_COLOR;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_command <= twcp_pkg::CMD_LOAD;
        s_texture_side <= '0;
        s_col_x <= '0;
        s_row_y <= '0;
        s_texel_color <= '0;
        s_top_row <= '0;
        s_bottom_row <= '0;
        s_dist_from_top <= '0;
        s_wall_height <= '0;
        s_hit_x <= '0;
        s_hit_y <= '0;
        s_vertical_hit <= 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, registers at their reset values.
        send_load(0, 0, 0, 24'h000000);
        send_load(3, 63, 63, 24'hFFFFFF);
        send_load(1, 64, 0, 24'($urandom));
        send_load(2, 0, 64, 24'($urandom));
        send_load(2, 1023, 1023, 24'($urandom));
        render_at(0, 0, 0, 0, 1, 0, 64, 0, 0);
        render_at(3, 1023, 1023, 0, 1024, 32767, 1, 16'hFFFF, 1);
        render_at(1, 17, 5, 10, 100, 0, 90, 16'($urandom), 0);
        render_at(2, 512, 1023, 0, 1023, 0, 1023, 16'($urandom), 1);
        // inverted span: ceiling above both, floor wins in between, floor below both
        render_at(0, 100, 100, 600, 200, 0, 400, 16'($urandom), 0);
        render_at(0, 101, 400, 600, 200, 0, 400, 16'($urandom), 0);
        render_at(0, 102, 700, 600, 200, 0, 400, 16'($urandom), 0);
        render_at(1, 3, 1, 0, 10, 0, 0, 5, 0);
        render_at(2, 4, 5, 0, 10, -32768, 100, 7, 1);
        render_at(3, 8, 1023, 1024, 1024, 0, 1, 16'($urandom), 0);
        render_at(1, 9, 0, 0, 0, 0, 1, 16'($urandom), 1);
        render_at(1, 300, 450, 400, 528, -400, 128, 1000, 1);
        render_at(3, 9, 200, 100, 1024, 32767, 65535, 123, 0);
        settle();

        configure(24'hFFFFFF, 24'h000000, 24'd1);
        run_phase();
        configure(24'h000000, 24'hFFFFFF, 24'd1024);
        run_phase();
        configure(24'($urandom), 24'($urandom), 24'd0);
        run_phase();
        configure(24'($urandom), 24'($urandom), {13'($urandom), 11'h7FF});
        run_phase();
        configure(24'($urandom), 24'($urandom), 24'd640);
        run_phase();
        configure(24'($urandom), 24'($urandom), 24'($urandom_range(1, 1024)));
        run_phase();

        // Output held off while the input keeps offering, so the pipeline backs up.
        configure(24'($urandom), 24'($urandom), 24'($urandom_range(1, 1024)));
        hold_off_req = 1'b1;
        run_phase();

        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        configure(24'($urandom), 24'($urandom), 24'($urandom_range(1, 1024)));
        run_phase();

        if (sb.close_out() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// ===== files.f =====
sv/twcp_pkg.sv
sv/textured_wall_column_pixel.sv
bench/testbench.sv
